// ===== src/fwdf_pkg.sv =====
// ----------------------------------------------------------------------------
// fwdf_pkg
// Shared types and constants for the fixed-width decimal formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package fwdf_pkg;

  // Default number of character cells
  localparam int unsigned MaxDigitsDef = 10;

  // Field widths fixed by the item format
  localparam int unsigned ValueW = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned CharW  = 7;

  // ASCII codes
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChBlank = 7'h20;
  localparam logic [CharW-1:0] ChPoint = 7'h2E;

  // Reciprocal of ten, exact for 16-bit dividends: q = (v * DivMul) >> DivShift
  localparam logic [ValueW-1:0] DivMul   = 16'hCCCD;
  localparam int unsigned       DivShift = 19;

  // Input item
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] digit_count;
    logic [CountW-1:0] decimal_places;
  } fwdf_in_item_t;

  // Result item
  typedef struct packed {
    logic [CountW-1:0] position;
    logic [CharW-1:0]  character;
    logic              last;
  } fwdf_out_item_t;

  // Stack control handed to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } fwdf_cell_ctrl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BUILD = 3'b010,
    ST_EMIT  = 3'b100
  } fwdf_state_e;

endpackage

`default_nettype wire

// ===== src/fixed_width_decimal_formatter.sv =====
// The item is accepted in idle; the build pass then fills N cells and the emit
//   pass sends N characters, after which the sequencer returns to idle to take
//   the next item. N is the clamped field width; a zero width yields no output.
// The build pass yields one character per cycle from a single divide-by-ten unit.
// Reset (async, active low) returns the sequencer to idle; cell contents are
//   not cleared and are always rewritten before use.
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter
// Formats an unsigned value into a fixed-width ASCII field, leftmost first.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_width_decimal_formatter
  import fwdf_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fwdf_in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output fwdf_out_item_t      out_item_o
);

  fwdf_state_e       state_q, state_d;
  logic [CountW-1:0] n_q, n_d;
  logic [CountW-1:0] d_q, d_d;
  logic [CountW-1:0] k_q, k_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              zero_q, zero_d;

  logic [CountW-1:0] n_clamp;
  logic [ValueW-1:0] quot;
  logic [3:0]        rem;
  logic [CharW-1:0]  new_char;
  logic              use_digit;
  fwdf_cell_ctrl_t   cell_ctrl;
  logic [CharW-1:0]  cell_char [MAX_DIGITS];

  logic in_acc, out_acc, out_last;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;
  assign out_last = (pos_q == n_q - CountW'(1));

  // width clamp
  always_comb begin
    n_clamp = in_item_i.digit_count;
    if ({1'b0, in_item_i.digit_count} > 5'(MAX_DIGITS)) begin
      n_clamp = CountW'(MAX_DIGITS);
    end
  end

  fwdf_div10 u_div10 (
    .val_i  (val_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // character for position k from the right
  always_comb begin
    use_digit = 1'b0;
    if (zero_q) begin
      new_char = (k_q == '0) ? ChZero : ChBlank;
    end else if (d_q != '0 && k_q == d_q) begin
      new_char = ChPoint;
    end else if (val_q != '0) begin
      new_char  = ChZero + CharW'(rem);
      use_digit = 1'b1;
    end else if (d_q != '0 && k_q < d_q && d_q < n_q) begin
      new_char = ChZero;
    end else begin
      new_char = ChBlank;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    d_d     = d_q;
    k_d     = k_q;
    pos_d   = pos_q;
    val_d   = val_q;
    zero_d  = zero_q;
    cell_ctrl.push = 1'b0;
    cell_ctrl.pop  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d    = n_clamp;
          d_d    = in_item_i.decimal_places;
          val_d  = in_item_i.value;
          zero_d = (in_item_i.value == '0);
          k_d    = '0;
          if (n_clamp != '0) begin
            state_d = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        cell_ctrl.push = 1'b1;
        if (use_digit) begin
          val_d = quot;
        end
        k_d = k_q + CountW'(1);
        if (k_q == n_q - CountW'(1)) begin
          pos_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          cell_ctrl.pop = 1'b1;
          pos_d = pos_q + CountW'(1);
          if (out_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    d_q    <= d_d;
    k_q    <= k_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    zero_q <= zero_d;
  end

  // character stack: push at cell 0 while building, pop towards cell 0 on output
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic [CharW-1:0] left_c, right_c;
    if (i == 0) begin : g_first
      assign left_c = new_char;
    end else begin : g_mid
      assign left_c = cell_char[i-1];
    end
    if (i == MAX_DIGITS - 1) begin : g_end
      assign right_c = ChBlank;
    end else begin : g_inner
      assign right_c = cell_char[i+1];
    end
    fwdf_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .left_i  (left_c),
      .right_i (right_c),
      .char_o  (cell_char[i])
    );
  end

  // ports
  assign in_ready_o           = (state_q == ST_IDLE);
  assign out_valid_o          = (state_q == ST_EMIT);
  assign out_item_o.position  = pos_q;
  assign out_item_o.character = cell_char[0];
  assign out_item_o.last      = out_last;

endmodule

`default_nettype wire

// ===== src/fwdf_div10.sv =====
// ----------------------------------------------------------------------------
// fwdf_div10
// Divide a 16-bit value by ten: quotient and remainder digit.
// ----------------------------------------------------------------------------
`default_nettype none

module fwdf_div10
  import fwdf_pkg::*;
(
  input  wire logic [ValueW-1:0] val_i,
  output logic      [ValueW-1:0] quot_o,
  output logic      [3:0]        rem_o
);

  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   ten_q;

  // reciprocal multiply, then subtract ten times the quotient
  assign prod   = (2*ValueW)'(val_i) * (2*ValueW)'(DivMul);
  assign quot_o = ValueW'(prod >> DivShift);
  assign ten_q  = {quot_o[ValueW-4:0], 3'b000} + {quot_o[ValueW-2:0], 1'b0};
  assign rem_o  = 4'(val_i - ten_q);

endmodule

`default_nettype wire

// ===== src/fwdf_cell.sv =====
// ----------------------------------------------------------------------------
// fwdf_cell
// One character cell of the stack: takes from its left neighbour on push,
// from its right neighbour on pop, holds otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module fwdf_cell
  import fwdf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire fwdf_cell_ctrl_t  ctrl_i,
  input  wire logic [CharW-1:0] left_i,
  input  wire logic [CharW-1:0] right_i,
  output logic      [CharW-1:0] char_o
);

  logic [CharW-1:0] char_q, char_d;

  // neighbour select
  always_comb begin
    char_d = char_q;
    if (ctrl_i.push) begin
      char_d = left_i;
    end else if (ctrl_i.pop) begin
      char_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o = char_q;

endmodule

`default_nettype wire

// ===== src/fwdf_checker.sv =====
// ----------------------------------------------------------------------------
// fwdf_port_checker
// Port-level checks for the fixed-width decimal formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module fwdf_port_checker
  import fwdf_pkg::*;
(
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire fwdf_out_item_t out_item_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // no new item taken while a field is being sent
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while results pending");

  // positions step by one within a field
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last |=>
      out_valid_o && out_item_o.position == 4'($past(out_item_o.position) + 4'd1))
    else $error("position did not advance by one");

  // field ends after its last character
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.last |=> !out_valid_o)
    else $error("result after last character");

  // only digits, blanks and points appear
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.character >= ChZero &&
                     out_item_o.character <= 7'h39) ||
                    out_item_o.character == ChBlank ||
                    out_item_o.character == ChPoint)
    else $error("illegal character");

endmodule

bind fixed_width_decimal_formatter fwdf_port_checker u_fwdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
